// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the request TLP builder.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another on the next clock edge.
`define PTB_ASSERT_NEXT(label, cond, expect_next, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (cond) |=> (expect_next)) else $error(msg);

`endif

// ===== hdl/ptb_pkg.sv =====
// Package for the request TLP builder: command codes, TLP header constants,
// the queue entry type and the byte swap. No dependencies.
package ptb_pkg;

  // Request commands
  localparam logic [2:0] CMD_MEM_RD  = 3'd0;
  localparam logic [2:0] CMD_MEM_WR  = 3'd1;
  localparam logic [2:0] CMD_CFG0_RD = 3'd2;
  localparam logic [2:0] CMD_CFG0_WR = 3'd3;
  localparam logic [2:0] CMD_CFG1_RD = 3'd4;
  localparam logic [2:0] CMD_CFG1_WR = 3'd5;

  // TLP header fields
  localparam logic [2:0] FMT_READ  = 3'd0;
  localparam logic [2:0] FMT_WRITE = 3'd2;
  localparam logic [4:0] TYPE_MEM  = 5'd0;
  localparam logic [4:0] TYPE_CFG0 = 5'd4;
  localparam logic [4:0] TYPE_CFG1 = 5'd5;
  localparam logic [9:0] LENGTH_ONE = 10'd1;
  localparam logic [3:0] FIRST_DW_BE = 4'hF;
  localparam logic [3:0] LAST_BE   = 4'h0;

  // Word positions within a packet
  localparam logic [1:0] WORD_HDR0 = 2'd0;
  localparam logic [1:0] WORD_HDR1 = 2'd1;
  localparam logic [1:0] WORD_HDR2 = 2'd2;
  localparam logic [1:0] WORD_DATA = 2'd3;

  // One classified request, header words already swapped
  typedef struct packed {
    logic [31:0] hdr0;
    logic [31:0] hdr1;
    logic [31:0] hdr2;
    logic [31:0] data;
    logic        is_write;
  } entry_t;

  function automatic logic [31:0] byte_swap(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ===== hdl/ptb_intf.sv =====
// Channel interfaces of the request TLP builder: request in, packet words out.
// Valid/ready handshake; no package dependency.
interface ptb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [7:0]  bus_number;
  logic [4:0]  device_number;
  logic [2:0]  function_number;

  modport source (output valid, cmd, address, write_data, bus_number, device_number,
                  function_number, input ready);
  modport sink (input valid, cmd, address, write_data, bus_number, device_number,
                function_number, output ready);
endinterface

interface ptb_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_word;
  logic        start_of_packet;
  logic        end_of_packet;

  modport source (output valid, packet_word, start_of_packet, end_of_packet, input ready);
  modport sink (input valid, packet_word, start_of_packet, end_of_packet, output ready);
endinterface

// ===== hdl/pcie_request_tlp_builder.sv =====
// Request TLP builder: each request on req becomes a 3-DW request TLP on tlp,
// three byte-swapped header words for a read and one unswapped data word more
// for a write, first word marked start_of_packet and last end_of_packet. The
// output sends one word per cycle while tlp.ready is high; that output register
// sets the throughput. A front end builds headers and assigns the 8-bit tag,
// and a QUEUE_DEPTH-entry queue lets it accept further requests while earlier
// packets drain. Commands 6 and 7 are accepted and dropped without using a
// tag. Write the requester id only while no packet is pending. No clearing
// pass after reset.
module pcie_request_tlp_builder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [15:0] cfg_write_data,
  ptb_req_if.sink     req,
  ptb_word_if.source  tlp
);
  import ptb_pkg::*;
  `include "assert_macros.svh"

  logic [15:0] req_id;
  logic        q_full;
  logic        q_push;
  entry_t      q_entry;
  logic        q_pop;
  logic        q_valid;
  entry_t      q_head;

  // Hold the requester id register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_id <= '0;
    end else if (cfg_write_enable) begin
      req_id <= cfg_write_data;
    end
  end

  ptb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req_id  (req_id),
    .req     (req),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  ptb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  ptb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_entry (q_head),
    .pop        (q_pop),
    .tlp        (tlp)
  );

  `PTB_ASSERT(a_no_overflow, !(q_push && q_full), "push into full request queue")
  `PTB_ASSERT(a_pop_valid, !(q_pop && !q_valid), "pop from empty request queue")
  `PTB_ASSERT_NEXT(a_head_held, q_valid && !q_pop, q_valid, "queue head lost without pop")
  `PTB_ASSERT(a_marks, !(tlp.valid && tlp.start_of_packet && tlp.end_of_packet), "both marks")

endmodule

// ===== hdl/ptb_front.sv =====
// Front end: accepts requests, classifies the command, builds the header words
// and owns the tag counter. Depends on ptb_pkg and ptb_req_if.
module ptb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       req_id,
  ptb_req_if.sink           req,
  input  logic              q_full,
  output logic              q_push,
  output ptb_pkg::entry_t   q_entry
);
  import ptb_pkg::*;

  logic [7:0]  tag;
  logic        cmd_ok;
  logic        is_write;
  logic        is_mem;
  logic [4:0]  tlp_type;
  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;

  // Classify the command; unused codes are taken and dropped
  always_comb begin
    cmd_ok   = 1'b1;
    is_write = 1'b0;
    is_mem   = 1'b0;
    tlp_type = TYPE_MEM;
    case (req.cmd)
      CMD_MEM_RD: begin
        is_mem = 1'b1;
      end
      CMD_MEM_WR: begin
        is_mem   = 1'b1;
        is_write = 1'b1;
      end
      CMD_CFG0_RD: begin
        tlp_type = TYPE_CFG0;
      end
      CMD_CFG0_WR: begin
        tlp_type = TYPE_CFG0;
        is_write = 1'b1;
      end
      CMD_CFG1_RD: begin
        tlp_type = TYPE_CFG1;
      end
      CMD_CFG1_WR: begin
        tlp_type = TYPE_CFG1;
        is_write = 1'b1;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  // Build the three header words
  always_comb begin
    word0 = {(is_write ? FMT_WRITE : FMT_READ), tlp_type, 14'd0, LENGTH_ONE};
    word1 = {req_id, tag, LAST_BE, FIRST_DW_BE};
    if (is_mem) begin
      word2 = req.address;
    end else begin
      word2 = {req.bus_number, req.device_number, req.function_number, 16'd0} | req.address;
    end
  end

  assign req.ready        = !q_full;
  assign q_push           = req.valid && !q_full && cmd_ok;
  assign q_entry.hdr0     = byte_swap(word0);
  assign q_entry.hdr1     = byte_swap(word1);
  assign q_entry.hdr2     = byte_swap(word2);
  assign q_entry.data     = req.write_data;
  assign q_entry.is_write = is_write;

  // Advance the tag once per queued request
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else if (q_push) begin
      tag <= tag + 8'd1;
    end
  end

endmodule

// ===== hdl/ptb_queue.sv =====
// Short request queue between front and back end, held in registers.
// Depends on ptb_pkg for the entry type.
module ptb_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ptb_pkg::entry_t   push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ptb_pkg::entry_t   head_entry
);
  import ptb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == DEPTH_CNT);
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/ptb_back.sv =====
// Back end: walks the queue head word by word into a registered output word.
// Depends on ptb_pkg and ptb_word_if.
module ptb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  ptb_pkg::entry_t   head_entry,
  output logic              pop,
  ptb_word_if.source        tlp
);
  import ptb_pkg::*;

  logic [1:0]  idx;
  logic        last;
  logic        load;
  logic [31:0] word_sel;
  logic        out_valid;
  logic [31:0] out_word;
  logic        out_sop;
  logic        out_eop;

  // Select the word at the current position
  always_comb begin
    case (idx)
      WORD_HDR0: word_sel = head_entry.hdr0;
      WORD_HDR1: word_sel = head_entry.hdr1;
      WORD_HDR2: word_sel = head_entry.hdr2;
      default:   word_sel = head_entry.data;
    endcase
  end

  assign last = head_entry.is_write ? (idx == WORD_DATA) : (idx == WORD_HDR2);
  assign load = head_valid && (!out_valid || tlp.ready);
  assign pop  = load && last;

  // Advance the word position; drop back to the first word after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= WORD_HDR0;
    end else if (load) begin
      idx <= last ? WORD_HDR0 : idx + 2'd1;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (tlp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= word_sel;
      out_sop  <= (idx == WORD_HDR0);
      out_eop  <= last;
    end
  end

  assign tlp.valid           = out_valid;
  assign tlp.packet_word     = out_word;
  assign tlp.start_of_packet = out_sop;
  assign tlp.end_of_packet   = out_eop;

endmodule
